// File: src/assert_macros.svh
// assertion helpers for the checker file (cfts_checker.sv)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CFTS_ASSERT_IMPL(name, clk_s, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CFTS_ASSERT_NEXT(name, clk_s, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cfts_pkg.sv
package cfts_pkg;

	// fixed field widths
	localparam int unsigned PAYLOAD_W  = 64;
	localparam int unsigned ID_W       = 29;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned ENTRY_W    = 2;

	// input command codes
	localparam logic CMD_MERGE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// frame kind codes
	localparam logic KIND_ONCE   = 1'b0;
	localparam logic KIND_CYCLIC = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic merge;
		logic snap;
		logic walk;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_end;
	} status_t;

endpackage

// File: src/cyclic_frame_tx_scheduler.sv
// Cyclic frame transmit scheduler.
// Input channel: an item is taken at a clock edge with start high and busy low.
// command selects a merge request (fields written into entry_index of the
// table if in range and not all zero) or a one millisecond tick.
// A merge request completes at the accepting edge; busy stays low, so
// another item may follow in the next cycle. It never produces results.
// A tick raises busy for the whole walk: the controller walks one slot
// per cycle, first every entry's one-shot slot, then every entry's cyclic
// slot, 2*ENTRY_COUNT slots in all.
// Result channel: each due frame is shown for one cycle with strobe high,
// in the cycle after its slot, in slot order; last_frame marks the final frame
// of the tick. A tick with nothing due gives no strobe.
// The receiver cannot stall: results are not held or repeated.
// Reset clears every entry (payload, id, interval, flags, countdown) to zero
// and leaves the block idle.
module cyclic_frame_tx_scheduler #(
	parameter int unsigned ENTRY_COUNT = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [cfts_pkg::ENTRY_W-1:0]         entry_index,
	input  logic [cfts_pkg::PAYLOAD_W-1:0]       payload,
	input  logic [cfts_pkg::ID_W-1:0]            frame_id,
	input  logic [cfts_pkg::INTERVAL_W-1:0]      interval,
	input  logic                                 cyclic_enable,
	input  logic                                 one_shot,
	output logic                                 strobe,
	output logic [cfts_pkg::ENTRY_W-1:0]         source_entry,
	output logic [cfts_pkg::ID_W-1:0]            out_id,
	output logic [cfts_pkg::PAYLOAD_W-1:0]       out_payload,
	output logic                                 send_kind,
	output logic                                 last_frame
);
	import cfts_pkg::*;

	cmd_t    cmd;
	status_t stat;

	// sequencing
	cfts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	// table and result path
	cfts_datapath #(
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.entry_index   (entry_index),
		.payload       (payload),
		.frame_id      (frame_id),
		.interval      (interval),
		.cyclic_enable (cyclic_enable),
		.one_shot      (one_shot),
		.strobe        (strobe),
		.source_entry  (source_entry),
		.out_id        (out_id),
		.out_payload   (out_payload),
		.send_kind     (send_kind),
		.last_frame    (last_frame)
	);

endmodule

// File: src/cfts_ctrl.sv
module cfts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             command,
	input  cfts_pkg::status_t stat,
	output cfts_pkg::cmd_t   cmd,
	output logic             busy
);
	import cfts_pkg::*;

	state_t state_q;
	state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = (state_q == ST_WALK);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_TICK) begin
						cmd.snap   = 1'b1;
						state_next = ST_WALK;
					end else begin
						cmd.merge = 1'b1;
					end
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_end) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// File: src/cfts_datapath.sv
module cfts_datapath #(
	parameter int unsigned ENTRY_COUNT = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cfts_pkg::cmd_t                       cmd,
	output cfts_pkg::status_t                    stat,
	input  logic [cfts_pkg::ENTRY_W-1:0]         entry_index,
	input  logic [cfts_pkg::PAYLOAD_W-1:0]       payload,
	input  logic [cfts_pkg::ID_W-1:0]            frame_id,
	input  logic [cfts_pkg::INTERVAL_W-1:0]      interval,
	input  logic                                 cyclic_enable,
	input  logic                                 one_shot,
	output logic                                 strobe,
	output logic [cfts_pkg::ENTRY_W-1:0]         source_entry,
	output logic [cfts_pkg::ID_W-1:0]            out_id,
	output logic [cfts_pkg::PAYLOAD_W-1:0]       out_payload,
	output logic                                 send_kind,
	output logic                                 last_frame
);
	import cfts_pkg::*;

	localparam int unsigned IDX_W    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int unsigned SLOTS    = 2 * ENTRY_COUNT;
	localparam int unsigned POS_W    = $clog2(SLOTS);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(SLOTS - 1);
	localparam logic [POS_W-1:0] POS_CYC  = POS_W'(ENTRY_COUNT);

	// entry table
	logic [PAYLOAD_W-1:0]  payload_q   [ENTRY_COUNT];
	logic [ID_W-1:0]       id_q        [ENTRY_COUNT];
	logic [INTERVAL_W-1:0] interval_q  [ENTRY_COUNT];
	logic [INTERVAL_W-1:0] countdown_q [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0] cyclic_q;
	logic [ENTRY_COUNT-1:0] pending_q;
	logic [ENTRY_COUNT-1:0] armed_q;

	// frames due on the current tick: one-shot slots low, cyclic slots high
	logic [SLOTS-1:0] due_q;
	logic [POS_W-1:0] pos_q;

	logic [ENTRY_COUNT-1:0] enabled;
	logic [ENTRY_COUNT-1:0] fire;
	logic                   req_nonzero;
	logic                   req_in_range;
	logic [IDX_W-1:0]       wr_idx;
	logic                   slot_kind;
	logic [POS_W-1:0]       slot_ent_pos;
	logic [IDX_W-1:0]       rd_idx;
	logic [SLOTS-1:0]       later_due;
	logic                   strobe_q;
	logic [ENTRY_W-1:0]     src_q;
	logic [ID_W-1:0]        id_out_q;
	logic [PAYLOAD_W-1:0]   payload_out_q;
	logic                   kind_q;
	logic                   last_q;

	// per entry cyclic decision
	always_comb begin
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			enabled[i] = cyclic_q[i] && (interval_q[i] != '0);
			fire[i]    = enabled[i] && (!armed_q[i] || (countdown_q[i] <= INTERVAL_W'(1)));
		end
	end

	// request decode
	assign req_nonzero  = (payload != '0) || (frame_id != '0) || (interval != '0)
		|| cyclic_enable || one_shot;
	assign req_in_range = 32'(entry_index) < 32'(ENTRY_COUNT);
	assign wr_idx       = IDX_W'(entry_index);

	// walk slot decode
	assign slot_kind    = (pos_q >= POS_CYC);
	assign slot_ent_pos = slot_kind ? (pos_q - POS_CYC) : pos_q;
	assign rd_idx       = IDX_W'(slot_ent_pos);
	assign later_due    = (due_q >> pos_q) >> 1;
	assign stat.walk_end = (pos_q == LAST_POS);

	// table, merge and tick snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				payload_q[i]   <= '0;
				id_q[i]        <= '0;
				interval_q[i]  <= '0;
				countdown_q[i] <= '0;
			end
			cyclic_q  <= '0;
			pending_q <= '0;
			armed_q   <= '0;
			due_q     <= '0;
			pos_q     <= '0;
		end else begin
			if (cmd.merge && req_nonzero && req_in_range) begin
				payload_q[wr_idx]  <= payload;
				if (frame_id != '0) begin
					id_q[wr_idx] <= frame_id;
				end
				cyclic_q[wr_idx]   <= cyclic_enable;
				interval_q[wr_idx] <= interval;
				pending_q[wr_idx]  <= pending_q[wr_idx] | one_shot;
			end
			if (cmd.snap) begin
				due_q     <= {fire, pending_q};
				pending_q <= '0;
				pos_q     <= '0;
				for (int i = 0; i < ENTRY_COUNT; i++) begin
					if (!enabled[i]) begin
						armed_q[i]     <= 1'b0;
						countdown_q[i] <= '0;
					end else if (fire[i]) begin
						armed_q[i]     <= 1'b1;
						countdown_q[i] <= interval_q[i];
					end else begin
						countdown_q[i] <= countdown_q[i] - INTERVAL_W'(1);
					end
				end
			end
			if (cmd.walk && !stat.walk_end) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.walk && due_q[pos_q];
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.walk && due_q[pos_q]) begin
			src_q         <= ENTRY_W'(rd_idx);
			id_out_q      <= id_q[rd_idx];
			payload_out_q <= payload_q[rd_idx];
			kind_q        <= slot_kind ? KIND_CYCLIC : KIND_ONCE;
			last_q        <= (later_due == '0);
		end
	end

	assign strobe       = strobe_q;
	assign source_entry = src_q;
	assign out_id       = id_out_q;
	assign out_payload  = payload_out_q;
	assign send_kind    = kind_q;
	assign last_frame   = last_q;

endmodule

// File: src/cfts_checker.sv
`include "assert_macros.svh"

module cfts_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic command,
	input logic strobe,
	input logic last_frame
);
	import cfts_pkg::*;

	// a frame only follows a cycle spent walking a tick
	`CFTS_ASSERT_IMPL(a_strobe_after_walk, clk, arst_n, strobe, $past(busy), "frame without walk")

	// the final frame of a tick is not followed at once by another
	`CFTS_ASSERT_NEXT(a_last_ends_tick, clk, arst_n, strobe && last_frame, !strobe, "frame after last")

	// an accepted tick starts a walk
	`CFTS_ASSERT_NEXT(a_tick_busy, clk, arst_n, start && !busy && (command == CMD_TICK), busy, "tick not taken")

	// a merge request completes in its accepting cycle
	`CFTS_ASSERT_NEXT(a_merge_idle, clk, arst_n, start && !busy && (command == CMD_MERGE), !busy && !strobe, "merge stalled")

endmodule

bind cyclic_frame_tx_scheduler cfts_checker u_cfts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.command    (command),
	.strobe     (strobe),
	.last_frame (last_frame)
);
